// ===== src/artb_pkg.sv =====
package artb_pkg;

  // field widths of the request and result
  localparam int IDX_W    = 8;
  localparam int ADDR_W   = 48;
  localparam int WEIGHT_W = 16;
  localparam int TOTAL_W  = 32;
  localparam int COUNT_W  = 9;

  // most ranges that an 8-bit index can reach
  localparam int RANGE_CAP = 256;

  // request kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [IDX_W-1:0]    range_index;
    logic [ADDR_W-1:0]   address;
    logic [WEIGHT_W-1:0] time_weight;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   matched_index;
    logic [TOTAL_W-1:0] range_total;
  } result_t;

  // total table operations
  typedef enum logic [1:0] {
    ACC_ZERO,
    ACC_ADD,
    ACC_READ
  } acc_op_t;

  typedef struct packed {
    logic                valid;
    acc_op_t             op;
    logic [IDX_W-1:0]    index;
    logic [WEIGHT_W-1:0] weight;
  } acc_cmd_t;

  typedef struct packed {
    logic               clearing;
    logic               done;
    logic [TOTAL_W-1:0] total;
  } acc_rsp_t;

  // start table scan control
  typedef struct packed {
    logic              go;
    logic              load;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] address;
  } scan_cmd_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] index;
  } scan_rsp_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_TOTAL
  } state_t;

endpackage

// ===== src/address_range_time_binner_core.sv =====
// Address range time binner.
// Request channel: request is taken at a clock edge with start high and busy low.
// kind selects a range start load, a pc time sample or a range total read.
// Result channel: done is high for exactly one cycle with result; the receiver
// cannot stall, so results are never held back. Every request gives one result.
// Configuration: cfg_we writes cfg_data into the range count; write only while idle.
// A load, a miss on an empty table or an unused kind is answered from the execute
// state; a read adds a fetch from the total table, and a sample adds a scan of the
// ranges in use and, on a match, an add in the total table. The sample time is set
// by the scan, which reads one start entry per cycle from a single read port in table order.
// busy is low again in the cycle that done is shown, so one request follows
// directly after the previous result.
// After reset the total table is cleared one entry per cycle, with busy high; the start
// table is not cleared and the range count is 1.
module address_range_time_binner_core #(
  parameter int NUM_RANGES = 256,
  parameter int ADDR_BITS  = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  artb_pkg::request_t            request,
  output logic                          done,
  output artb_pkg::result_t             result,
  input  logic                          cfg_we,
  input  logic [artb_pkg::COUNT_W-1:0]  cfg_data
);
  import artb_pkg::*;

  localparam int CAP = (NUM_RANGES < RANGE_CAP) ? NUM_RANGES : RANGE_CAP;

  state_t             state;
  state_t             state_next;
  request_t           req;
  logic [COUNT_W-1:0] range_count;
  logic [COUNT_W-1:0] n_eff;
  logic [IDX_W-1:0]   tot_idx;
  logic               idx_ok;
  logic               read_ok;
  logic               res_set;
  result_t            res_next;
  scan_cmd_t          scan_cmd;
  scan_rsp_t          scan_rsp;
  acc_cmd_t           acc_cmd;
  acc_rsp_t           acc_rsp;

  // ranges in use and index checks
  always_comb begin
    n_eff   = (range_count > COUNT_W'(CAP)) ? COUNT_W'(CAP) : range_count;
    idx_ok  = (32'(req.range_index) < NUM_RANGES);
    read_ok = ({1'b0, req.range_index} < n_eff);
  end

  assign busy = (state != ST_IDLE);

  // sequencer next state and commands
  always_comb begin
    state_next = state;
    scan_cmd   = '0;
    acc_cmd    = '0;
    res_set    = 1'b0;
    res_next   = '0;
    unique case (state)
      ST_CLEAR: begin
        if (!acc_rsp.clearing) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        res_set    = 1'b1;
        unique case (req.kind)
          KIND_LOAD: begin
            res_next.matched_index = req.range_index;
            if (idx_ok) begin
              scan_cmd.load    = 1'b1;
              scan_cmd.index   = req.range_index;
              scan_cmd.address = req.address;
              acc_cmd.valid    = 1'b1;
              acc_cmd.op       = ACC_ZERO;
              acc_cmd.index    = req.range_index;
              res_next.hit     = 1'b1;
            end
          end
          KIND_SAMPLE: begin
            if (n_eff != '0) begin
              res_set          = 1'b0;
              scan_cmd.go      = 1'b1;
              scan_cmd.address = req.address;
              state_next       = ST_SCAN;
            end
          end
          KIND_READ: begin
            res_next.matched_index = req.range_index;
            if (read_ok) begin
              res_set       = 1'b0;
              acc_cmd.valid = 1'b1;
              acc_cmd.op    = ACC_READ;
              acc_cmd.index = req.range_index;
              state_next    = ST_TOTAL;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          if (scan_rsp.found) begin
            acc_cmd.valid  = 1'b1;
            acc_cmd.op     = ACC_ADD;
            acc_cmd.index  = scan_rsp.index;
            acc_cmd.weight = req.time_weight;
            state_next     = ST_TOTAL;
          end else begin
            res_set    = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_TOTAL: begin
        if (acc_rsp.done) begin
          res_set                = 1'b1;
          res_next.hit           = 1'b1;
          res_next.matched_index = tot_idx;
          res_next.range_total   = acc_rsp.total;
          state_next             = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      done        <= 1'b0;
      range_count <= COUNT_W'(1);
    end else begin
      state <= state_next;
      done  <= res_set;
      if (cfg_we) begin
        range_count <= cfg_data;
      end
    end
  end

  // request, index and result holding registers
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      req <= request;
    end
    if (acc_cmd.valid) begin
      tot_idx <= acc_cmd.index;
    end
    if (res_set) begin
      result <= res_next;
    end
  end

  artb_scan #(
    .NUM_RANGES (NUM_RANGES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .cmd   (scan_cmd),
    .count (n_eff),
    .rsp   (scan_rsp)
  );

  artb_accum #(
    .NUM_RANGES (NUM_RANGES)
  ) u_accum (
    .clk (clk),
    .rst (rst),
    .cmd (acc_cmd),
    .rsp (acc_rsp)
  );

  // a result is shown only once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // no result in the cycle right after a request is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result too early after request");

  // a miss never carries a total
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.hit) |-> (result.range_total == '0))
    else $error("miss with nonzero total");

endmodule

// ===== src/artb_scan.sv =====
module artb_scan #(
  parameter int NUM_RANGES = 256,
  parameter int ADDR_BITS  = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  artb_pkg::scan_cmd_t       cmd,
  input  logic [artb_pkg::COUNT_W-1:0] count,
  output artb_pkg::scan_rsp_t       rsp
);
  import artb_pkg::*;

  localparam int AW = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;

  logic [ADDR_BITS-1:0] start_mem [NUM_RANGES];
  logic [ADDR_BITS-1:0] rdata;
  logic [ADDR_BITS-1:0] pc;
  logic [COUNT_W-1:0]   n_reg;
  logic [COUNT_W-1:0]   rd_cnt;
  logic [COUNT_W-1:0]   d_idx;
  logic                 active;
  logic                 dv;
  logic                 prev_above;
  logic                 above;
  logic                 hit_mid;
  logic                 hit_last;
  logic                 last;

  // start table: one write port for loads, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_mem[AW'(cmd.index)] <= ADDR_BITS'(cmd.address);
    end
    rdata <= start_mem[AW'(rd_cnt)];
  end

  // boundary test on the entry that just came back
  always_comb begin
    above    = (pc >= rdata);
    last     = (d_idx == (n_reg - COUNT_W'(1)));
    hit_mid  = dv && (d_idx != '0) && prev_above && !above;
    hit_last = dv && last && above;
    rsp.done  = dv && (hit_mid || hit_last || last);
    rsp.found = hit_mid || hit_last;
    rsp.index = hit_mid ? IDX_W'(d_idx - COUNT_W'(1)) : IDX_W'(d_idx);
  end

  // scan control, one entry read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      dv     <= 1'b0;
    end else if (cmd.go) begin
      active <= 1'b1;
      dv     <= 1'b0;
    end else if (rsp.done) begin
      active <= 1'b0;
      dv     <= 1'b0;
    end else if (active && (rd_cnt < n_reg)) begin
      dv <= 1'b1;
    end else begin
      dv <= 1'b0;
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      pc     <= ADDR_BITS'(cmd.address);
      n_reg  <= count;
      rd_cnt <= '0;
    end else if (active && (rd_cnt < n_reg)) begin
      d_idx  <= rd_cnt;
      rd_cnt <= rd_cnt + COUNT_W'(1);
    end
    if (dv) begin
      prev_above <= above;
    end
  end

  // a match always lies inside the ranges in use
  a_match_in_use: assert property (@(posedge clk) disable iff (rst)
    (rsp.done && rsp.found) |-> ({1'b0, rsp.index} < n_reg))
    else $error("scan match beyond ranges in use");

endmodule

// ===== src/artb_accum.sv =====
module artb_accum #(
  parameter int NUM_RANGES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  artb_pkg::acc_cmd_t cmd,
  output artb_pkg::acc_rsp_t rsp
);
  import artb_pkg::*;

  localparam int AW = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int CW = $clog2(NUM_RANGES + 1);

  logic [TOTAL_W-1:0] total_mem [NUM_RANGES];
  logic [TOTAL_W-1:0] rdata;
  logic [CW-1:0]      clr_cnt;
  logic               clearing;
  logic               pend;
  acc_op_t            pend_op;
  logic [AW-1:0]      pend_idx;
  logic [WEIGHT_W-1:0] pend_w;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sum_sat;

  assign clearing = (clr_cnt != CW'(NUM_RANGES));

  // saturating add on the fetched total
  always_comb begin
    sum     = {1'b0, rdata} + (TOTAL_W + 1)'(pend_w);
    sum_sat = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  end

  always_comb begin
    rsp.clearing = clearing;
    rsp.done     = pend;
    rsp.total    = (pend_op == ACC_ADD) ? sum_sat : rdata;
  end

  // total table: clear pass, zero on load, write back of the add
  always_ff @(posedge clk) begin
    if (clearing) begin
      total_mem[AW'(clr_cnt)] <= '0;
    end else if (cmd.valid && (cmd.op == ACC_ZERO)) begin
      total_mem[AW'(cmd.index)] <= '0;
    end else if (pend && (pend_op == ACC_ADD)) begin
      total_mem[pend_idx] <= sum_sat;
    end
    rdata <= total_mem[AW'(cmd.index)];
  end

  // clear counter and pending fetch
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      pend    <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + CW'(1);
      end
      pend <= cmd.valid && (cmd.op != ACC_ZERO);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      pend_op  <= cmd.op;
      pend_idx <= AW'(cmd.index);
      pend_w   <= cmd.weight;
    end
  end

  // no request reaches the table while the clear pass runs
  a_no_cmd_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cmd.valid)
    else $error("total table access during clear pass");

endmodule
